>>> rtl/core/sprcol_pkg.sv
`timescale 1ns / 1ps

package sprcol_pkg;

  // field widths of the transfer payloads
  localparam int REQ_W     = 2;
  localparam int PIXEL_X_W = 9;
  localparam int SPRITE_W  = 6;

  // line and sprite table sizes (LINE_WIDTH up to 2**PIXEL_X_W)
  localparam int LINE_WIDTH  = 512;
  localparam int MAX_SPRITES = 64;
  localparam int LINE_AW     = $clog2(LINE_WIDTH);
  localparam int SPR_AW      = $clog2(MAX_SPRITES);

  // line generation tag kept with each owner entry
  localparam int EPOCH_W = 4;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX   = {EPOCH_W{1'b1}};
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_STALE = '0;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR = 2'd0,
    REQ_DRAW  = 2'd1,
    REQ_READ  = 2'd2
  } req_t;

  typedef struct packed {
    logic [EPOCH_W-1:0]  epoch;
    logic [SPRITE_W-1:0] owner;
  } owner_entry_t;

  localparam int ENTRY_W = $bits(owner_entry_t);

  typedef struct packed {
    logic               busy;
    logic               wrap;
    logic [EPOCH_W-1:0] epoch;
  } clr_status_t;

  typedef struct packed {
    logic              set_a;
    logic [SPR_AW-1:0] idx_a;
    logic              set_b;
    logic [SPR_AW-1:0] idx_b;
  } flag_set_t;

endpackage

>>> rtl/core/sprcol_in_if.sv
`timescale 1ns / 1ps

interface sprcol_in_if import sprcol_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [REQ_W-1:0]     req_type;
  logic [PIXEL_X_W-1:0] pixel_x;
  logic [SPRITE_W-1:0]  sprite_id;
  logic                 pixel_opaque;

  modport source (output valid, req_type, pixel_x, sprite_id, pixel_opaque, input ready);
  modport sink   (input valid, req_type, pixel_x, sprite_id, pixel_opaque, output ready);
endinterface

>>> rtl/core/sprcol_out_if.sv
`timescale 1ns / 1ps

interface sprcol_out_if import sprcol_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                hit;
  logic [SPRITE_W-1:0] prior_owner;
  logic                flag_value;

  modport source (output valid, hit, prior_owner, flag_value, input ready);
  modport sink   (input valid, hit, prior_owner, flag_value, output ready);
endinterface

>>> rtl/core/sprite_pixel_collision_buffer.sv
`timescale 1ns / 1ps

// Sprite collision line buffer.
// in_chan carries requests: clear line, draw pixel (x, sprite, opaque) or
// read a sprite's sticky collision flag. Every request gives exactly one
// transfer on out_chan: hit and prior owner for draws, flag for reads,
// all zero otherwise.
// Throughput: one request per cycle while out_chan is ready and no
// sweep runs. Owner RAM is read at the input transfer and written back
// when the request leaves stage one; a write to the pixel just read is
// forwarded. Stage one holds each request, and its result is then
// registered in the output register. Each pixel entry carries a line
// tag, so a clear is a tag bump. Every 15th clear runs out of tags and
// is followed by a sweep of all 512 owner RAM entries with in_chan.ready
// low. Reset: synchronous, active low. The same sweep runs after reset
// before the first request is taken; sprite flags clear at once.
// A stalled receiver holds the result in the output register; one more
// request is still taken and held, then in_chan.ready drops.
module sprite_pixel_collision_buffer import sprcol_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  sprcol_in_if.sink    in_chan,
  sprcol_out_if.source out_chan
);

  clr_status_t        st;
  logic               pass_we;
  logic [LINE_AW-1:0] pass_addr;

  logic                 s1_valid_r, s1_valid_nxt;
  logic [REQ_W-1:0]     s1_req_r;
  logic [PIXEL_X_W-1:0] s1_px_r;
  logic [SPRITE_W-1:0]  s1_sid_r;
  logic                 s1_opq_r;

  logic                out_valid_r, out_valid_nxt;
  logic                out_hit_r;
  logic [SPRITE_W-1:0] out_prior_r;
  logic                out_flag_r;

  logic               fwd_valid_r;
  logic [LINE_AW-1:0] fwd_addr_r;
  owner_entry_t       fwd_data_r;

  logic               in_fire, s1_done, s1_we, clear_commit;
  logic [LINE_AW-1:0] s1_addr;
  logic               px_ok, sid_ok, draw_ok, ent_valid, hit, old_ok;
  logic               flag_rd, flag_value;
  owner_entry_t       rd_entry, entry, s1_wdata;
  logic               ram_we;
  logic [LINE_AW-1:0] ram_waddr;
  owner_entry_t       ram_wdata;
  flag_set_t          fset;

  assign s1_done = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign clear_commit = s1_done && (s1_req_r == REQ_CLEAR);

  // hold off input during a sweep, while stage one is blocked, and while a tag-exhausting clear is leaving
  assign in_chan.ready = !st.busy &&
                         (!s1_valid_r || (s1_done && !(s1_req_r == REQ_CLEAR && st.wrap)));
  assign in_fire = in_chan.valid && in_chan.ready;

  assign s1_addr = s1_px_r[LINE_AW-1:0];
  assign entry   = (fwd_valid_r && fwd_addr_r == s1_addr) ? fwd_data_r : rd_entry;

  assign px_ok     = 32'(s1_px_r) < LINE_WIDTH;
  assign sid_ok    = 32'(s1_sid_r) < MAX_SPRITES;
  assign draw_ok   = (s1_req_r == REQ_DRAW) && s1_opq_r && px_ok && sid_ok;
  assign ent_valid = (entry.epoch == st.epoch);
  assign hit       = draw_ok && ent_valid;
  assign old_ok    = 32'(entry.owner) < MAX_SPRITES;

  assign s1_we          = s1_done && draw_ok;
  assign s1_wdata.epoch = st.epoch;
  assign s1_wdata.owner = s1_sid_r;

  assign ram_we    = pass_we || s1_we;
  assign ram_waddr = pass_we ? pass_addr : s1_addr;
  always_comb begin
    ram_wdata = s1_wdata;
    if (pass_we) begin
      ram_wdata.epoch = EPOCH_STALE;
      ram_wdata.owner = '0;
    end
  end

  assign fset.set_a = s1_done && hit;
  assign fset.idx_a = s1_sid_r[SPR_AW-1:0];
  assign fset.set_b = s1_done && hit && old_ok;
  assign fset.idx_b = entry.owner[SPR_AW-1:0];

  assign flag_rd = (s1_req_r == REQ_READ) && sid_ok;

  sprcol_owner_ram #(
    .DEPTH (LINE_WIDTH),
    .WIDTH (ENTRY_W)
  ) u_owner_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (in_chan.pixel_x[LINE_AW-1:0]),
    .rdata (rd_entry)
  );

  sprcol_clear_seq u_clear_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .clear_commit (clear_commit),
    .status       (st),
    .pass_we      (pass_we),
    .pass_addr    (pass_addr)
  );

  sprcol_flags u_flags (
    .clk     (clk),
    .rst_n   (rst_n),
    .set     (fset),
    .rd_idx  (s1_sid_r[SPR_AW-1:0]),
    .rd_flag (flag_value)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_done) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_done) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (ram_we) begin
        fwd_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r <= in_chan.req_type;
      s1_px_r  <= in_chan.pixel_x;
      s1_sid_r <= in_chan.sprite_id;
      s1_opq_r <= in_chan.pixel_opaque;
    end
    if (ram_we) begin
      fwd_addr_r <= ram_waddr;
      fwd_data_r <= ram_wdata;
    end
    if (s1_done) begin
      out_hit_r   <= hit;
      out_prior_r <= hit ? entry.owner : '0;
      out_flag_r  <= flag_rd && flag_value;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.hit         = out_hit_r;
  assign out_chan.prior_owner = out_prior_r;
  assign out_chan.flag_value  = out_flag_r;

  a_no_draw_during_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_we && st.busy))
    else $error("owner write-back overlaps the clearing sweep");

  a_stalled_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_done) |=> s1_valid_r)
    else $error("stalled request lost from stage one");

  a_clear_bumps_tag: assert property (@(posedge clk) disable iff (!rst_n)
    (clear_commit && !st.wrap && !st.busy) |=> (st.epoch == EPOCH_W'($past(st.epoch) + 1'b1)))
    else $error("clear did not advance the line tag");

  a_accept_no_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !st.busy)
    else $error("sweep started behind an accepted request");

endmodule

>>> rtl/core/sprcol_owner_ram.sv
`timescale 1ns / 1ps

module sprcol_owner_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read-first: a same-address write in this cycle is not seen
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/sprcol_clear_seq.sv
`timescale 1ns / 1ps

module sprcol_clear_seq import sprcol_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               clear_commit,
  output clr_status_t        status,
  output logic               pass_we,
  output logic [LINE_AW-1:0] pass_addr
);

  logic               busy_r, busy_nxt;
  logic [LINE_AW-1:0] cnt_r, cnt_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;

  always_comb begin
    busy_nxt  = busy_r;
    cnt_nxt   = cnt_r;
    epoch_nxt = epoch_r;
    if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LINE_AW'(LINE_WIDTH - 1)) begin
        busy_nxt  = 1'b0;
        epoch_nxt = EPOCH_FIRST;
      end
    end else if (clear_commit) begin
      if (epoch_r == EPOCH_MAX) begin
        // tags exhausted: sweep every entry back to stale
        busy_nxt = 1'b1;
        cnt_nxt  = '0;
      end else begin
        epoch_nxt = epoch_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b1;
      cnt_r   <= '0;
      epoch_r <= EPOCH_FIRST;
    end else begin
      busy_r  <= busy_nxt;
      cnt_r   <= cnt_nxt;
      epoch_r <= epoch_nxt;
    end
  end

  assign status.busy  = busy_r;
  assign status.wrap  = (epoch_r == EPOCH_MAX);
  assign status.epoch = epoch_r;
  assign pass_we      = busy_r;
  assign pass_addr    = cnt_r;

endmodule

>>> rtl/core/sprcol_flags.sv
`timescale 1ns / 1ps

module sprcol_flags import sprcol_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  flag_set_t         set,
  input  logic [SPR_AW-1:0] rd_idx,
  output logic              rd_flag
);

  logic [MAX_SPRITES-1:0] flags_r, flags_nxt;

  always_comb begin
    flags_nxt = flags_r;
    if (set.set_a) begin
      flags_nxt[set.idx_a] = 1'b1;
    end
    if (set.set_b) begin
      flags_nxt[set.idx_b] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r <= flags_nxt;
    end
  end

  assign rd_flag = flags_r[rd_idx];

endmodule

>>> verif/sprcol_checker.sv
`timescale 1ns / 1ps

module sprcol_checker import sprcol_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  sprcol_in_if  req_mon,
  sprcol_out_if res_mon,
  output int    fail_count,
  output int    outstanding
);

  typedef struct packed {
    logic                hit;
    logic [SPRITE_W-1:0] prior_owner;
    logic                flag_value;
  } outcome_t;

  logic [SPRITE_W-1:0] pixel_owner [LINE_WIDTH];
  bit                  pixel_taken [LINE_WIDTH];
  bit                  sprite_hit  [MAX_SPRITES];
  outcome_t            outcome_q [$];
  int                  errors;

  function automatic outcome_t collision_outcome(
    logic [REQ_W-1:0]     req,
    logic [PIXEL_X_W-1:0] x,
    logic [SPRITE_W-1:0]  sid,
    logic                 opaque
  );
    outcome_t r;
    int       i;
    r = '0;
    case (req)
      REQ_CLEAR: begin
        for (i = 0; i < LINE_WIDTH; i++) pixel_taken[i] = 1'b0;
      end
      REQ_DRAW: begin
        if (opaque && x < LINE_WIDTH && sid < MAX_SPRITES) begin
          if (pixel_taken[x]) begin
            // both sprites get the sticky flag, redraw by the owner included
            r.hit         = 1'b1;
            r.prior_owner = pixel_owner[x];
            sprite_hit[sid] = 1'b1;
            if (pixel_owner[x] < MAX_SPRITES) sprite_hit[pixel_owner[x]] = 1'b1;
          end
          pixel_owner[x] = sid;
          pixel_taken[x] = 1'b1;
        end
      end
      REQ_READ: begin
        if (sid < MAX_SPRITES) r.flag_value = sprite_hit[sid];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_fail(string what, outcome_t want, outcome_t seen);
    errors++;
    if (errors <= 10)
      $display("%0t %s: expected hit=%0d prior=%0d flag=%0d, got hit=%0d prior=%0d flag=%0d",
               $realtime, what, want.hit, want.prior_owner, want.flag_value,
               seen.hit, seen.prior_owner, seen.flag_value);
  endtask

  always @(posedge clk) begin
    outcome_t seen;
    outcome_t want;
    if (!rst_n) begin
      for (int i = 0; i < LINE_WIDTH; i++) pixel_taken[i] = 1'b0;
      for (int i = 0; i < MAX_SPRITES; i++) sprite_hit[i] = 1'b0;
      outcome_q.delete();
      errors = 0;
    end else begin
      // older results leave before this edge's request is predicted
      if (res_mon.valid && res_mon.ready) begin
        seen = {res_mon.hit, res_mon.prior_owner, res_mon.flag_value};
        if (outcome_q.size() == 0) begin
          report_fail("result transfer with nothing pending", '0, seen);
        end else begin
          want = outcome_q.pop_front();
          if (seen.hit !== want.hit || seen.prior_owner !== want.prior_owner ||
              seen.flag_value !== want.flag_value)
            report_fail("result mismatch", want, seen);
        end
      end
      if (req_mon.valid && req_mon.ready)
        outcome_q.push_back(collision_outcome(req_mon.req_type, req_mon.pixel_x,
                                              req_mon.sprite_id, req_mon.pixel_opaque));
    end
    fail_count  <= errors;
    outstanding <= outcome_q.size();
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import sprcol_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int               NUM_ITEMS  = 800;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   outstanding;
  int   sent;
  int   res_wait;
  bit   calm;

  sprcol_in_if  req_chan ();
  sprcol_out_if res_chan ();

  sprite_pixel_collision_buffer uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_chan),
    .out_chan (res_chan)
  );

  sprcol_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_mon     (req_chan),
    .res_mon     (res_chan),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int idle_draw();
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  // result side: a fresh random stall, possibly none, drawn after every transfer
  always @(posedge clk) begin
    int w;
    if (!rst_n) begin
      res_chan.ready <= 1'b0;
      res_wait       <= 0;
    end else if (res_chan.valid && res_chan.ready) begin
      w = idle_draw();
      res_chan.ready <= (w == 0);
      res_wait       <= w;
    end else if (res_wait > 1) begin
      res_wait <= res_wait - 1;
    end else begin
      res_wait       <= 0;
      res_chan.ready <= 1'b1;
    end
  end

  task automatic send_req(logic [REQ_W-1:0] req, logic [PIXEL_X_W-1:0] x,
                          logic [SPRITE_W-1:0] sid, logic opaque);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      req_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_chan.valid        <= 1'b1;
    req_chan.req_type     <= req;
    req_chan.pixel_x      <= x;
    req_chan.sprite_id    <= sid;
    req_chan.pixel_opaque <= opaque;
    do @(posedge clk); while (!(req_chan.valid && req_chan.ready));
    sent++;
  endtask

  initial begin
    int base;
    int span;
    int n;
    bit few;
    rst_n                 = 1'b0;
    req_chan.valid        = 1'b0;
    req_chan.req_type     = REQ_CLEAR;
    req_chan.pixel_x      = '0;
    req_chan.sprite_id    = '0;
    req_chan.pixel_opaque = 1'b0;
    res_chan.ready        = 1'b0;
    calm                  = 1'b1;
    sent                  = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // flags are clear after reset
    send_req(REQ_READ,  9'd0,   6'd0,  1'b0);
    send_req(REQ_READ,  9'd511, 6'd63, 1'b1);
    send_req(REQ_CLEAR, 9'd0,   6'd0,  1'b0);
    send_req(REQ_DRAW,  9'd0,   6'd0,  1'b1);
    send_req(REQ_DRAW,  9'd0,   6'd63, 1'b1);   // hit on sprite 0
    send_req(REQ_DRAW,  9'd511, 6'd63, 1'b1);
    send_req(REQ_DRAW,  9'd511, 6'd63, 1'b1);   // redraw by the owner
    send_req(REQ_DRAW,  9'd5,   6'd5,  1'b0);   // transparent, leaves pixel free
    send_req(REQ_DRAW,  9'd5,   6'd6,  1'b1);
    send_req(REQ_READ,  9'd0,   6'd0,  1'b0);
    send_req(REQ_READ,  9'd0,   6'd63, 1'b0);
    send_req(REQ_READ,  9'd0,   6'd5,  1'b0);
    send_req(REQ_READ,  9'd0,   6'd6,  1'b0);
    send_req(REQ_UNUSED, 9'd511, 6'd63, 1'b1);
    send_req(REQ_CLEAR, 9'd511, 6'd63, 1'b1);
    send_req(REQ_DRAW,  9'd0,   6'd1,  1'b1);   // line was cleared: no hit
    send_req(REQ_READ,  9'd0,   6'd1,  1'b0);
    send_req(REQ_DRAW,  9'h1AA, 6'd42, 1'b1);
    send_req(REQ_DRAW,  9'h155, 6'd21, 1'b1);
    send_req(REQ_DRAW,  9'h1AA, 6'd21, 1'b1);
    send_req(REQ_READ,  9'h155, 6'd42, 1'b1);
    send_req(REQ_READ,  9'h1AA, 6'd21, 1'b0);

    sent = 0;
    while (sent < NUM_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 4) != 0) begin
        // one scanline: clear, then draws within a random span after a start point, mixed with some flag reads
        base = $urandom_range(0, LINE_WIDTH - 1);
        case ($urandom_range(0, 2))
          0:       span = 3;
          1:       span = 31;
          default: span = LINE_WIDTH - 1;
        endcase
        few = ($urandom_range(0, 1) == 1);
        send_req(REQ_CLEAR, PIXEL_X_W'($urandom_range(0, LINE_WIDTH - 1)),
                 SPRITE_W'($urandom_range(0, MAX_SPRITES - 1)), 1'($urandom_range(0, 1)));
        n = $urandom_range(4, 40);
        repeat (n) begin
          if ($urandom_range(0, 9) == 0)
            send_req(REQ_READ, PIXEL_X_W'($urandom_range(0, LINE_WIDTH - 1)),
                     SPRITE_W'(few ? $urandom_range(0, 7) : $urandom_range(0, MAX_SPRITES - 1)),
                     1'($urandom_range(0, 1)));
          else
            send_req(REQ_DRAW, PIXEL_X_W'(base + $urandom_range(0, span)),
                     SPRITE_W'(few ? $urandom_range(0, 7) : $urandom_range(0, MAX_SPRITES - 1)),
                     $urandom_range(0, 4) != 0);
        end
      end else begin
        repeat ($urandom_range(1, 6))
          send_req(REQ_W'($urandom_range(0, 3)), PIXEL_X_W'($urandom_range(0, LINE_WIDTH - 1)),
                   SPRITE_W'($urandom_range(0, MAX_SPRITES - 1)), 1'($urandom_range(0, 1)));
      end
    end
    req_chan.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[sprite_pixel_collision_buffer] OK");
    end else begin
      $display("[sprite_pixel_collision_buffer] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[sprite_pixel_collision_buffer] ERROR");
    $finish;
  end

endmodule
